// ===== sv/tfa_pkg.sv =====
// shared types and constants for the triangle face attribute pipeline
package tfa_pkg;

   localparam int CW = 24;                  // coordinate width
   localparam int CF = 12;                  // coordinate fraction bits
   localparam int NF = 14;                  // normal fraction bits
   localparam int EW = CW + 1;              // edge vector width
   localparam int PW = 2 * EW;              // cross product term width
   localparam int CXW = PW + 1;             // cross product component width
   localparam int AW = PW;                  // cross product magnitude width
   localparam int NB = 30;                  // normalized magnitude width
   localparam int SQW = 2 * NB;
   localparam int L2W = SQW + 2;            // squared length width
   localparam int LW = L2W / 2;             // length width
   localparam int SQ_N = LW;                // square root cells
   localparam int SREM_W = LW + 4;
   localparam int QW = NF + 1;              // quotient bits, one per divide cell
   localparam int NUMW = NB + NF + 1;
   localparam int DREM_W = LW;
   localparam int OXW = 41;                 // x component / area width
   localparam int BW = 6;                   // bit length width
   localparam int GRP_N = (AW + 7) / 8;
   localparam int SW = CW + 2;              // coordinate sum width
   localparam int RECIP_SH = 27;
   localparam int CPW = SW + RECIP_SH;
   localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(((1 << RECIP_SH) + 1) / 3);
   localparam int AREA_E0 = NB + 1 + CF;
   localparam int RW = AREA_E0 + 1;
   localparam logic [OXW-1:0] AREA_MAX = {1'b0, {(OXW - 1){1'b1}}};
   localparam int IN_TDATA_W = ((9 * CW + 7) / 8) * 8;
   localparam int OUT_TDATA_W = ((OXW + 2 * CW + 7) / 8) * 8;
   localparam int OUT_TUSER_W = 4;

   typedef enum logic [2:0] {
      KIND_NORMAL   = 3'd0,
      KIND_CENTROID = 3'd1,
      KIND_BOX_MIN  = 3'd2,
      KIND_BOX_MAX  = 3'd3,
      KIND_AREA     = 3'd4
   } kind_type;

   typedef logic [2:0][CW-1:0] vec3_type;

   typedef struct packed {
      vec3_type mn;
      vec3_type mx;
      vec3_type cen;
   } geo_type;

   typedef struct packed {
      logic [2:0][NB-1:0] s;
      logic [2:0]         neg;
      logic [BW-1:0]      b;
      geo_type            geo;
   } mid_type;

   typedef struct packed {
      logic [LW-1:0]  len;
      logic [OXW-1:0] area;
      logic [2:0]     neg;
      logic           degen;
      geo_type        geo;
   } tail_type;

   typedef struct packed {
      logic [SREM_W-1:0] rem;
      logic [LW-1:0]     root;
      logic [L2W-1:0]    rad;
   } sqrt_state_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic [QW-1:0]     num;
      logic [QW-1:0]     quo;
   } div_state_type;

   typedef struct packed {
      vec3_type       nrm;
      geo_type        geo;
      logic [OXW-1:0] area;
      logic           degen;
   } face_type;

endpackage

// ===== sv/tfa_sqrt_cell.sv =====
// one square root cell: settles one root bit per stage
module tfa_sqrt_cell (
   input  logic                    clock,
   input  logic                    en,
   input  tfa_pkg::sqrt_state_type st_i,
   output tfa_pkg::sqrt_state_type st_o
);
   import tfa_pkg::*;

   sqrt_state_type st_ff, st_in;
   logic [SREM_W-1:0] rem_t, trial;
   logic ge;

   always_comb begin
      rem_t = {st_i.rem[SREM_W-3:0], st_i.rad[L2W-1 -: 2]};
      trial = {{(SREM_W - LW - 2){1'b0}}, st_i.root, 2'b01};
      ge = rem_t >= trial;
      st_in.rem = ge ? (rem_t - trial) : rem_t;
      st_in.root = {st_i.root[LW-2:0], ge};
      st_in.rad = {st_i.rad[L2W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

// ===== sv/tfa_div_cell.sv =====
// one restoring divide cell: settles one quotient bit per stage
module tfa_div_cell (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tfa_pkg::LW-1:0]      den,
   input  tfa_pkg::div_state_type      st_i,
   output tfa_pkg::div_state_type      st_o
);
   import tfa_pkg::*;

   div_state_type st_ff, st_in;
   logic [DREM_W:0] rem_t, diff;
   logic ge;

   always_comb begin
      rem_t = {st_i.rem, st_i.num[QW-1]};
      diff = rem_t - {1'b0, den};
      ge = rem_t >= {1'b0, den};
      st_in.rem = ge ? diff[DREM_W-1:0] : rem_t[DREM_W-1:0];
      st_in.num = {st_i.num[QW-2:0], 1'b0};
      st_in.quo = {st_i.quo[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

// ===== sv/tfa_out_buf.sv =====
// result buffer: holds one finished face and sends its five items
module tfa_out_buf (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  tfa_pkg::face_type                   face_i,
   output logic                                ready_o,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tfa_pkg::OUT_TDATA_W-1:0]     rsp_tdata,
   output logic [tfa_pkg::OUT_TUSER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);
   import tfa_pkg::*;

   face_type face_ff;
   logic busy_ff, busy_in;
   kind_type kind_ff, kind_in;
   logic [OXW-1:0] cx;
   logic [CW-1:0] cy, cz;
   logic take;

   assign take = busy_ff && rsp_tready;
   assign ready_o = !busy_ff || (rsp_tready && kind_ff == KIND_AREA);

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      if (load) begin
         busy_in = 1'b1;
         kind_in = KIND_NORMAL;
      end else if (take) begin
         if (kind_ff == KIND_AREA) begin
            busy_in = 1'b0;
         end else begin
            kind_in = kind_type'(kind_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         kind_ff <= KIND_NORMAL;
      end else begin
         busy_ff <= busy_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         face_ff <= face_i;
      end
   end

   always_comb begin
      cx = '0;
      cy = '0;
      cz = '0;
      case (kind_ff)
         KIND_NORMAL: begin
            cx = {{(OXW - CW){face_ff.nrm[0][CW-1]}}, face_ff.nrm[0]};
            cy = face_ff.nrm[1];
            cz = face_ff.nrm[2];
         end
         KIND_CENTROID: begin
            cx = {{(OXW - CW){face_ff.geo.cen[0][CW-1]}}, face_ff.geo.cen[0]};
            cy = face_ff.geo.cen[1];
            cz = face_ff.geo.cen[2];
         end
         KIND_BOX_MIN: begin
            cx = {{(OXW - CW){face_ff.geo.mn[0][CW-1]}}, face_ff.geo.mn[0]};
            cy = face_ff.geo.mn[1];
            cz = face_ff.geo.mn[2];
         end
         KIND_BOX_MAX: begin
            cx = {{(OXW - CW){face_ff.geo.mx[0][CW-1]}}, face_ff.geo.mx[0]};
            cy = face_ff.geo.mx[1];
            cz = face_ff.geo.mx[2];
         end
         KIND_AREA: begin
            cx = face_ff.area;
         end
         default: begin
            cx = '0;
         end
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata = {{(OUT_TDATA_W - OXW - 2 * CW){1'b0}}, cz, cy, cx};
   assign rsp_tuser = {face_ff.degen, kind_ff};
   assign rsp_tlast = kind_ff == KIND_AREA;

endmodule

// ===== sv/triangle_face_attributes.sv =====
// triangle face attributes: normal, centroid, bounding box and area per triangle
//
//  channel  direction  content
//  req_     in         one triangle, nine Q12.12 coordinates
//  rsp_     out        five items per triangle: normal, centroid, min, max, area
//
// a triangle can be taken every cycle while the pipeline flows; the output
// sends five transfers per triangle, so the sustained triangle rate is set
// by the output. the first result is offered after 8 front stages,
// 31 square root cells, one area stage, 15 divide cells per normal
// component and the output buffer.
// reset clears the valid bits and the output buffer's busy and kind state only.
// when the last stage holds a face the buffer cannot take, the whole pipeline holds.
module triangle_face_attributes (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
   input  logic [tfa_pkg::IN_TDATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // comp_x, comp_y, comp_z, zero fill
   output logic [tfa_pkg::OUT_TDATA_W-1:0]     rsp_tdata,
   // item_kind, degenerate
   output logic [tfa_pkg::OUT_TUSER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);
   import tfa_pkg::*;

   logic adv, buf_ready, vld_last, load;

   // front stage 1: edges, box, centroid sum
   logic vld1_ff;
   logic signed [2:0][EW-1:0] e1_ff, e1_in, e2_ff, e2_in;
   vec3_type mn1_ff, mn1_in, mx1_ff, mx1_in;
   logic [2:0][SW-1:0] cs1_ff, cs1_in;
   logic [2:0] cn1_ff, cn1_in;

   // stage 2: products
   logic vld2_ff;
   logic [5:0][PW-1:0] pr2_ff, pr2_in;
   vec3_type mn2_ff, mx2_ff;
   logic [2:0][CPW-1:0] cp2_ff, cp2_in;
   logic [2:0] cn2_ff;

   // stage 3: cross product magnitudes, centroid
   logic vld3_ff;
   logic [2:0][AW-1:0] a3_ff, a3_in;
   logic [2:0] neg3_ff, neg3_in;
   geo_type geo3_ff, geo3_in;

   // stage 4: leading byte search
   logic vld4_ff;
   logic [2:0][AW-1:0] a4_ff;
   logic [2:0] neg4_ff;
   geo_type geo4_ff;
   logic [2:0] grp4_ff, grp4_in;
   logic [7:0] byt4_ff, byt4_in;

   // stage 5: bit length
   logic vld5_ff;
   logic [2:0][AW-1:0] a5_ff;
   logic [2:0] neg5_ff;
   geo_type geo5_ff;
   logic [BW-1:0] b5_ff, b5_in;

   // stage 6: normalized magnitudes
   logic vld6_ff;
   logic [2:0][NB-1:0] s6_ff, s6_in;
   logic [2:0] neg6_ff;
   geo_type geo6_ff;
   logic [BW-1:0] b6_ff;

   // stage 7: squares
   logic vld7_ff;
   logic [2:0][SQW-1:0] sq7_ff, sq7_in;
   mid_type m7_ff;

   // stage 8: squared length
   logic vld8_ff;
   logic [L2W-1:0] l2_8_ff;
   mid_type m8_ff;

   // square root chain
   sqrt_state_type sq_st [0:SQ_N];
   mid_type mid_ff [0:SQ_N-1];
   logic mvld_ff [0:SQ_N-1];

   // area stage and divide chain
   tail_type tail_ff [0:QW];
   tail_type tail_in;
   logic tvld_ff [0:QW];
   div_state_type dv [0:2][0:QW];
   div_state_type dinit_ff [0:2];
   div_state_type dinit_in [0:2];

   face_type face;

   assign vld_last = tvld_ff[QW];
   assign adv = !vld_last || buf_ready;
   assign load = vld_last && buf_ready;
   assign req_tready = adv;

   // ---------------- stage 1
   always_comb begin
      logic signed [CW-1:0] p, q, r;
      logic signed [SW-1:0] s;
      for (int i = 0; i < 3; i++) begin
         p = req_tdata[i * CW +: CW];
         q = req_tdata[(3 + i) * CW +: CW];
         r = req_tdata[(6 + i) * CW +: CW];
         e1_in[i] = EW'(q) - EW'(p);
         e2_in[i] = EW'(r) - EW'(p);
         mn1_in[i] = p;
         if (q < $signed(mn1_in[i])) mn1_in[i] = q;
         if (r < $signed(mn1_in[i])) mn1_in[i] = r;
         mx1_in[i] = p;
         if (q > $signed(mx1_in[i])) mx1_in[i] = q;
         if (r > $signed(mx1_in[i])) mx1_in[i] = r;
         s = SW'(p) + SW'(q) + SW'(r);
         cn1_in[i] = s[SW-1];
         cs1_in[i] = (s[SW-1] ? (SW'(0) - s) : s) + SW'(1);
      end
   end

   // ---------------- stage 2
   // elements of a packed array are unsigned, so the signed view is explicit
   always_comb begin
      pr2_in[0] = PW'($signed(e1_ff[1]) * $signed(e2_ff[2]));
      pr2_in[1] = PW'($signed(e1_ff[2]) * $signed(e2_ff[1]));
      pr2_in[2] = PW'($signed(e1_ff[2]) * $signed(e2_ff[0]));
      pr2_in[3] = PW'($signed(e1_ff[0]) * $signed(e2_ff[2]));
      pr2_in[4] = PW'($signed(e1_ff[0]) * $signed(e2_ff[1]));
      pr2_in[5] = PW'($signed(e1_ff[1]) * $signed(e2_ff[0]));
      for (int i = 0; i < 3; i++) begin
         cp2_in[i] = CPW'(cs1_ff[i]) * CPW'(RECIP);
      end
   end

   // ---------------- stage 3
   always_comb begin
      logic [CXW-1:0] c;
      logic [CW-1:0] qv;
      for (int i = 0; i < 3; i++) begin
         c = {pr2_ff[2 * i][PW-1], pr2_ff[2 * i]}
             - {pr2_ff[2 * i + 1][PW-1], pr2_ff[2 * i + 1]};
         neg3_in[i] = c[CXW-1];
         a3_in[i] = c[CXW-1] ? AW'(CXW'(0) - c) : AW'(c);
         qv = cp2_ff[i][RECIP_SH +: CW];
         geo3_in.cen[i] = cn2_ff[i] ? (CW'(0) - qv) : qv;
      end
      geo3_in.mn = mn2_ff;
      geo3_in.mx = mx2_ff;
   end

   // ---------------- stage 4: bit length of the largest equals that of the or
   always_comb begin
      logic [GRP_N*8-1:0] o;
      o = (GRP_N * 8)'(a3_ff[0] | a3_ff[1] | a3_ff[2]);
      grp4_in = '0;
      byt4_in = o[7:0];
      for (int g = 0; g < GRP_N; g++) begin
         if (|o[g * 8 +: 8]) begin
            grp4_in = 3'(g);
            byt4_in = o[g * 8 +: 8];
         end
      end
   end

   // ---------------- stage 5
   always_comb begin
      logic [3:0] bl;
      bl = '0;
      for (int k = 0; k < 8; k++) begin
         if (byt4_ff[k]) bl = 4'(k + 1);
      end
      b5_in = {grp4_ff, 3'b000} + BW'(bl);
   end

   // ---------------- stage 6
   always_comb begin
      logic [AW-1:0] tmp;
      for (int i = 0; i < 3; i++) begin
         if (b5_ff > BW'(NB)) tmp = a5_ff[i] >> (b5_ff - BW'(NB));
         else tmp = a5_ff[i] << (BW'(NB) - b5_ff);
         s6_in[i] = tmp[NB-1:0];
      end
   end

   // ---------------- stage 7
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq7_in[i] = SQW'(s6_ff[i]) * SQW'(s6_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_tvalid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         mn1_ff <= mn1_in;
         mx1_ff <= mx1_in;
         cs1_ff <= cs1_in;
         cn1_ff <= cn1_in;
         pr2_ff <= pr2_in;
         mn2_ff <= mn1_ff;
         mx2_ff <= mx1_ff;
         cp2_ff <= cp2_in;
         cn2_ff <= cn1_ff;
         a3_ff <= a3_in;
         neg3_ff <= neg3_in;
         geo3_ff <= geo3_in;
         a4_ff <= a3_ff;
         neg4_ff <= neg3_ff;
         geo4_ff <= geo3_ff;
         grp4_ff <= grp4_in;
         byt4_ff <= byt4_in;
         a5_ff <= a4_ff;
         neg5_ff <= neg4_ff;
         geo5_ff <= geo4_ff;
         b5_ff <= b5_in;
         s6_ff <= s6_in;
         neg6_ff <= neg5_ff;
         geo6_ff <= geo5_ff;
         b6_ff <= b5_ff;
         sq7_ff <= sq7_in;
         m7_ff.s <= s6_ff;
         m7_ff.neg <= neg6_ff;
         m7_ff.b <= b6_ff;
         m7_ff.geo <= geo6_ff;
         l2_8_ff <= L2W'(sq7_ff[0]) + L2W'(sq7_ff[1]) + L2W'(sq7_ff[2]);
         m8_ff <= m7_ff;
      end
   end

   // ---------------- square root chain
   always_comb begin
      sq_st[0].rem = '0;
      sq_st[0].root = '0;
      sq_st[0].rad = l2_8_ff;
   end

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      tfa_sqrt_cell u_cell (
         .clock (clock),
         .en    (adv),
         .st_i  (sq_st[k]),
         .st_o  (sq_st[k + 1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ_N; k++) mvld_ff[k] <= 1'b0;
      end else if (adv) begin
         mvld_ff[0] <= vld8_ff;
         for (int k = 1; k < SQ_N; k++) mvld_ff[k] <= mvld_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff[0] <= m8_ff;
         for (int k = 1; k < SQ_N; k++) mid_ff[k] <= mid_ff[k - 1];
      end
   end

   // ---------------- area and divide setup
   always_comb begin
      logic [LW-1:0] len;
      logic [BW-1:0] sh;
      logic [RW-1:0] rsum;
      logic [63:0] wide;
      logic [NUMW-1:0] num;
      mid_type m;
      m = mid_ff[SQ_N-1];
      len = sq_st[SQ_N].root;
      rsum = '0;
      wide = '0;
      tail_in.len = len;
      tail_in.neg = m.neg;
      tail_in.geo = m.geo;
      tail_in.degen = m.b == '0;
      if (m.b < BW'(AREA_E0)) begin
         sh = BW'(AREA_E0) - m.b;
         rsum = RW'(len) + (RW'(1) << (sh - BW'(1)));
         rsum = rsum >> sh;
         tail_in.area = OXW'(rsum);
      end else begin
         sh = m.b - BW'(AREA_E0);
         wide = 64'(len) << sh;
         tail_in.area = (wide > 64'(AREA_MAX)) ? AREA_MAX : OXW'(wide);
      end
      if (tail_in.degen) tail_in.area = '0;
      for (int i = 0; i < 3; i++) begin
         num = NUMW'({m.s[i], {NF{1'b0}}}) + NUMW'(len >> 1);
         dinit_in[i].rem = DREM_W'(num[NUMW-1:QW]);
         dinit_in[i].num = num[QW-1:0];
         dinit_in[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) tvld_ff[j] <= 1'b0;
      end else if (adv) begin
         tvld_ff[0] <= mvld_ff[SQ_N-1];
         for (int j = 1; j <= QW; j++) tvld_ff[j] <= tvld_ff[j - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tail_ff[0] <= tail_in;
         for (int j = 1; j <= QW; j++) tail_ff[j] <= tail_ff[j - 1];
         for (int i = 0; i < 3; i++) dinit_ff[i] <= dinit_in[i];
      end
   end

   // ---------------- divide chains, one per normal component
   for (genvar i = 0; i < 3; i++) begin : g_comp
      assign dv[i][0] = dinit_ff[i];
      for (genvar j = 0; j < QW; j++) begin : g_div
         tfa_div_cell u_cell (
            .clock (clock),
            .en    (adv),
            .den   (tail_ff[j].len),
            .st_i  (dv[i][j]),
            .st_o  (dv[i][j + 1])
         );
      end
   end

   always_comb begin
      logic [CW-1:0] qx;
      for (int i = 0; i < 3; i++) begin
         qx = CW'(dv[i][QW].quo);
         if (tail_ff[QW].degen) face.nrm[i] = '0;
         else if (tail_ff[QW].neg[i]) face.nrm[i] = CW'(0) - qx;
         else face.nrm[i] = qx;
      end
      face.geo = tail_ff[QW].geo;
      face.area = tail_ff[QW].area;
      face.degen = tail_ff[QW].degen;
   end

   tfa_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .face_i     (face),
      .ready_o    (buf_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/triangle_face_attributes_tb.sv =====
// self-checking testbench for the triangle face attribute block
module triangle_face_attributes_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfa_pkg::*;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct {
      kind_type        kind;
      logic [OXW-1:0]  cx;
      logic [CW-1:0]   cy;
      logic [CW-1:0]   cz;
      logic            degen;
      logic            last;
   } attr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic [OUT_TUSER_W-1:0] rsp_tuser;
   logic rsp_tlast;

   triangle_face_attributes i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [IN_TDATA_W-1:0] tri_queue[$];
   attr_type expected_attrs[$];
   int error_count = 0;
   int cycle_count = 0;
   bit quiet_phase = 0;     // no random idling
   int hold_rsp = 0;        // receiver hold-off cycles left
   bit pause_req = 0;
   bit req_accepted = 0;    // offered triangle went across at the last rising edge

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   task automatic queue_attr(input kind_type kind, input logic [OXW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [CW-1:0] cz,
                             input logic degen, input logic last);
      attr_type a;
      a.kind = kind;
      a.cx = cx;
      a.cy = cy;
      a.cz = cz;
      a.degen = degen;
      a.last = last;
      expected_attrs = {expected_attrs, a};
   endtask

   function automatic logic [63:0] root_of(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] third_of(input logic signed [63:0] s);
      logic signed [63:0] m, q;
      m = s < 0 ? -s : s;
      q = (m + 1) / 3;
      return s < 0 ? -q : q;
   endfunction

   // computes the five attribute transfers of one triangle
   task automatic predict_face(input logic [IN_TDATA_W-1:0] td);
      logic signed [63:0] v[9], e1[3], e2[3], cr[3], nrm[3], mn[3], mx[3], cen[3];
      logic [63:0] mag[3], amax, l2, len, q, area;
      bit neg[3];
      bit degen;
      int bl, e;
      for (int i = 0; i < 9; i++) v[i] = coord_type'(td[i*CW +: CW]);
      for (int i = 0; i < 3; i++) begin
         e1[i] = v[3+i] - v[i];
         e2[i] = v[6+i] - v[i];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      amax = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = cr[i] < 0;
         mag[i] = neg[i] ? -cr[i] : cr[i];
         if (mag[i] > amax) amax = mag[i];
         nrm[i] = 0;
      end
      degen = amax == 0;
      area = 0;
      if (!degen) begin
         bl = 0;
         while ((amax >> bl) != 0) bl++;
         for (int i = 0; i < 3; i++)
            mag[i] = bl > NB ? mag[i] >> (bl - NB) : mag[i] << (NB - bl);
         l2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         len = root_of(l2);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << NF) + len / 2) / len;
            nrm[i] = neg[i] ? -q : q;
         end
         e = 31 - bl + CF;
         if (e > 0) area = e >= 64 ? 0 : (len + (64'd1 << (e - 1))) >> e;
         else if (-e >= 33) area = 64'(AREA_MAX);
         else area = len << (-e);
         if (area > 64'(AREA_MAX)) area = 64'(AREA_MAX);
      end
      for (int i = 0; i < 3; i++) begin
         mn[i] = v[i];
         mx[i] = v[i];
         for (int j = 1; j < 3; j++) begin
            if (v[3*j+i] < mn[i]) mn[i] = v[3*j+i];
            if (v[3*j+i] > mx[i]) mx[i] = v[3*j+i];
         end
         cen[i] = third_of(v[i] + v[3+i] + v[6+i]);
      end
      queue_attr(KIND_NORMAL, OXW'(nrm[0]), CW'(nrm[1]), CW'(nrm[2]), degen, 1'b0);
      queue_attr(KIND_CENTROID, OXW'(cen[0]), CW'(cen[1]), CW'(cen[2]), degen, 1'b0);
      queue_attr(KIND_BOX_MIN, OXW'(mn[0]), CW'(mn[1]), CW'(mn[2]), degen, 1'b0);
      queue_attr(KIND_BOX_MAX, OXW'(mx[0]), CW'(mx[1]), CW'(mx[2]), degen, 1'b0);
      queue_attr(KIND_AREA, OXW'(area), '0, '0, degen, 1'b1);
   endtask

   function automatic logic [IN_TDATA_W-1:0] pack_tri(input coord_type c[9]);
      logic [IN_TDATA_W-1:0] td;
      td = '0;
      for (int i = 0; i < 9; i++) td[i*CW +: CW] = c[i];
      return td;
   endfunction

   task automatic queue_tri(input coord_type c[9]);
      tri_queue = {tri_queue, pack_tri(c)};
   endtask

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 8191)) - 4096;
         2: return $urandom_range(0, 1) ? coord_type'(24'h7fffff - $urandom_range(0, 15))
                                       : coord_type'(24'h800000 + $urandom_range(0, 15));
         default: return coord_type'($urandom_range(0, 3)) - 1;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_accepted) begin
            // hold the offered triangle
         end else if (tri_queue.size() != 0 && !pause_req &&
                      (quiet_phase || $urandom_range(0, 99) >= 10)) begin
            req_tvalid <= 1'b1;
            req_tdata <= tri_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         if (hold_rsp > 0) rsp_tready <= 1'b0;
         else rsp_tready <= quiet_phase || $urandom_range(0, 99) >= 10;
      end
   end

   always @(negedge clock) if (hold_rsp > 0) hold_rsp <= hold_rsp - 1;

   // input side bookkeeping and result monitor
   always @(posedge clock) begin
      attr_type exp_a;
      cycle_count <= cycle_count + 1;
      req_accepted = !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_face(req_tdata);
            void'(tri_queue.pop_front());
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_attrs.size() == 0) begin
               report("unexpected transfer");
            end else begin
               exp_a = expected_attrs.pop_front();
               if (rsp_tuser[2:0] !== exp_a.kind)
                  report($sformatf("kind %0d exp %0d", rsp_tuser[2:0], exp_a.kind));
               if (rsp_tuser[3] !== exp_a.degen)
                  report($sformatf("degenerate %b exp %b kind %0d", rsp_tuser[3],
                                   exp_a.degen, exp_a.kind));
               if (rsp_tlast !== exp_a.last)
                  report($sformatf("last %b exp %b", rsp_tlast, exp_a.last));
               if (rsp_tdata[0 +: OXW] !== exp_a.cx)
                  report($sformatf("kind %0d x %h exp %h", exp_a.kind,
                                   rsp_tdata[0 +: OXW], exp_a.cx));
               if (rsp_tdata[OXW +: CW] !== exp_a.cy)
                  report($sformatf("kind %0d y %h exp %h", exp_a.kind,
                                   rsp_tdata[OXW +: CW], exp_a.cy));
               if (rsp_tdata[OXW+CW +: CW] !== exp_a.cz)
                  report($sformatf("kind %0d z %h exp %h", exp_a.kind,
                                   rsp_tdata[OXW+CW +: CW], exp_a.cz));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("triangle_face_attributes_tb: errors");
         $finish;
      end
   end

   task automatic add_random(input int n);
      coord_type c[9];
      int mode;
      for (int k = 0; k < n; k++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++)
            c[i] = rand_coord(mode < 5 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
         // collinear and repeated vertices now and then
         if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
         queue_tri(c);
      end
   endtask

   task automatic drain();
      while (tri_queue.size() != 0 || expected_attrs.size() != 0) @(posedge clock);
   endtask

   initial begin
      coord_type c[9];
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, degenerate and small faces
      c = '{default: 0};
      queue_tri(c);
      c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
      queue_tri(c);
      c = '{-1, -1, -1, 1, 0, 0, 0, 1, 0};
      queue_tri(c);
      c = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh800000,
            24'sh800000, 24'sh7fffff, 24'sh7fffff};
      queue_tri(c);
      c = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000,
            24'sh7fffff, 24'sh800000, 24'sh800000};
      queue_tri(c);
      c = '{default: 24'sh800000};
      queue_tri(c);
      c = '{default: 24'sh7fffff};
      queue_tri(c);
      c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};               // collinear
      queue_tri(c);
      c = '{1, 0, 0, 0, 1, 0, 0, 0, 1};               // centroid rounds
      queue_tri(c);
      c = '{-2, 0, 0, 0, -2, 0, 0, 0, -1};
      queue_tri(c);
      add_random(10);
      drain();

      // long receiver hold-off; more faces than pipeline slots so the input stalls
      hold_rsp = 300;
      add_random(70);
      drain();

      quiet_phase = 1;
      add_random(40);
      repeat (20) @(posedge clock);
      // sender pauses until every result is back
      pause_req = 1;
      while (expected_attrs.size() != 0 || req_tvalid) @(posedge clock);
      pause_req = 0;
      drain();
      quiet_phase = 0;
      add_random(50);
      drain();

      repeat (80) @(posedge clock);
      if (error_count == 0) $display("triangle_face_attributes_tb: clean");
      else $display("triangle_face_attributes_tb: errors");
      $finish;
   end
endmodule

// ===== sim.f =====
sv/tfa_pkg.sv
sv/tfa_sqrt_cell.sv
sv/tfa_div_cell.sv
sv/tfa_out_buf.sv
sv/triangle_face_attributes.sv
verif/triangle_face_attributes_tb.sv
